// ===== rtl/pkpt_pkg.sv =====
package pkpt_pkg;

	localparam int TABLE_DEPTH_DEF   = 64;
	localparam int HANDLE_BITS_DEF   = 20;
	// handle bits kept in a table entry, whatever the port width
	localparam int HANDLE_FIELD_BITS = 20;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_BYTE   = 1'b1;

	localparam logic [2:0] STATUS_INSERTED  = 3'd0;
	localparam logic [2:0] STATUS_REPLACED  = 3'd1;
	localparam logic [2:0] STATUS_FULL      = 3'd2;
	localparam logic [2:0] STATUS_FOUND     = 3'd3;
	localparam logic [2:0] STATUS_NOT_FOUND = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_FOLD,
		ST_SCAN,
		ST_SHIFT,
		ST_WRITE
	} pkpt_state_t;

	// finished run: length and folded checksum, ready once folding is over
	typedef struct packed {
		logic        ready;
		logic [15:0] length;
		logic [15:0] checksum;
	} run_res_t;

endpackage

// ===== rtl/pkpt_run_acc.sv =====
module pkpt_run_acc import pkpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] data_byte,
	input  logic       data_valid,
	input  logic       last,
	output run_res_t   res
);

	localparam logic [1:0] FOLD_STEPS = 2'd3;

	logic [31:0] run_sum_q;
	logic [15:0] run_len_q;
	logic [7:0]  pend_high_q;
	logic        pend_odd_q;
	logic [31:0] fin_q;
	logic [15:0] fin_len_q;
	logic [1:0]  fold_cnt_q;

	logic [15:0] sum_add;
	logic [15:0] fin_add;
	logic [31:0] next_sum;
	logic [31:0] fin_sum;
	logic [15:0] next_len;
	logic [16:0] fold_sum;

	always_comb begin
		sum_add = (data_valid && pend_odd_q) ? {pend_high_q, data_byte} : 16'h0000;
		if (data_valid) begin
			fin_add = pend_odd_q ? {pend_high_q, data_byte} : {data_byte, 8'h00};
		end else begin
			fin_add = pend_odd_q ? {pend_high_q, 8'h00} : 16'h0000;
		end
		next_sum = run_sum_q + {16'h0000, sum_add};
		// sum as it stands with an odd last byte padded
		fin_sum  = run_sum_q + {16'h0000, fin_add};
		next_len = (data_valid && run_len_q != 16'hFFFF) ? run_len_q + 16'd1 : run_len_q;
		fold_sum = {1'b0, fin_q[15:0]} + {1'b0, fin_q[31:16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_sum_q   <= '0;
			run_len_q   <= '0;
			pend_high_q <= '0;
			pend_odd_q  <= 1'b0;
			fold_cnt_q  <= '0;
		end else begin
			if (byte_en) begin
				if (last) begin
					run_sum_q   <= '0;
					run_len_q   <= '0;
					pend_high_q <= '0;
					pend_odd_q  <= 1'b0;
					fold_cnt_q  <= FOLD_STEPS;
				end else begin
					run_sum_q <= next_sum;
					run_len_q <= next_len;
					if (data_valid) begin
						pend_odd_q  <= !pend_odd_q;
						pend_high_q <= pend_odd_q ? 8'h00 : data_byte;
					end
				end
			end else if (fold_cnt_q != 2'd0) begin
				fold_cnt_q <= fold_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_en && last) begin
			fin_q     <= fin_sum;
			fin_len_q <= next_len;
		end else if (fold_cnt_q != 2'd0) begin
			fin_q <= {15'h0000, fold_sum};
		end
	end

	assign res.ready    = (fold_cnt_q == 2'd0);
	assign res.length   = fin_len_q;
	assign res.checksum = fin_q[15:0];

endmodule

// ===== rtl/port_keyed_payload_table_unit.sv =====
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+------------------------------
// command   | cmd port src_port cookie_kind payload_handle    | start high, busy low
//           | data_byte data_valid last                       |
// result    | status out_length out_src_port out_checksum     | done, one cycle, no stall
//           | out_cookie_kind out_handle                      |
//
// A byte item that is not last leaves busy low, so the next item can follow.
// A lookup reads the table one entry a cycle until it finds the key or passes the last entry.
// An insert folds the checksum, scans to its slot, moves each later entry up by one
// through the single read and single write port, then writes; a new key on a full
// table is answered full and nothing is written.
// Reset empties the table at once; done marks each result for one cycle; no stall.
module port_keyed_payload_table_unit import pkpt_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cmd,
	input  logic [15:0]            port,
	input  logic [16:0]            src_port,
	input  logic [2:0]             cookie_kind,
	input  logic [HANDLE_BITS-1:0] payload_handle,
	input  logic [7:0]             data_byte,
	input  logic                   data_valid,
	input  logic                   last,
	output logic                   done,
	output logic [2:0]             status,
	output logic [15:0]            out_length,
	output logic [16:0]            out_src_port,
	output logic [15:0]            out_checksum,
	output logic [2:0]             out_cookie_kind,
	output logic [HANDLE_BITS-1:0] out_handle
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	// entry word: key, src_port, cookie, handle, length, checksum
	localparam int SUM_LSB = 0;
	localparam int LEN_LSB = 16;
	localparam int HND_LSB = 32;
	localparam int CK_LSB  = HND_LSB + HANDLE_BITS;
	localparam int SRC_LSB = CK_LSB + 3;
	localparam int KEY_LSB = SRC_LSB + 17;
	localparam int WW      = KEY_LSB + 16;

	logic [WW-1:0] mem [TABLE_DEPTH];

	pkpt_state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q;
	logic [AW-1:0]          pos_q;
	logic [AW-1:0]          sh_q;
	logic                   sh_done_q;
	logic [2:0]             ins_status_q;
	logic [15:0]            port_q;
	logic [16:0]            src_q;
	logic [2:0]             cookie_q;
	logic [HANDLE_BITS-1:0] handle_q;

	logic                   rd_vld_s1;
	logic [AW-1:0]          rd_addr_s1;
	logic [WW-1:0]          rdata_s1;

	logic                   accept;
	logic                   byte_en;
	run_res_t               run_res;
	logic [HANDLE_BITS-1:0] hmask;

	logic [15:0]            rd_key;
	logic                   lk_hit;
	logic                   ins_hit;
	logic                   ins_match;
	logic                   scan_end;
	logic                   stop;
	logic [CW-1:0]          pos;

	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic [WW-1:0]          wr_data;
	logic                   res_en;
	logic [2:0]             res_status;
	logic                   res_found;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign byte_en = accept && (cmd == CMD_BYTE);

	pkpt_run_acc u_run_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_en    (byte_en),
		.data_byte  (data_byte),
		.data_valid (data_valid),
		.last       (last),
		.res        (run_res)
	);

	always_comb begin
		for (int i = 0; i < HANDLE_BITS; i++) begin
			hmask[i] = (i < HANDLE_FIELD_BITS);
		end
	end

	always_comb begin
		rd_key    = rdata_s1[KEY_LSB +: 16];
		lk_hit    = rd_vld_s1 && (rd_key == port_q);
		ins_hit   = rd_vld_s1 && (port_q <= rd_key);
		ins_match = ins_hit && (rd_key == port_q);
		scan_end  = !rd_vld_s1 && (idx_q >= count_q);
		pos       = ins_hit ? CW'(rd_addr_s1) : count_q;
		stop      = (state_q == ST_LOOKUP) ? (lk_hit || scan_end) : (ins_hit || scan_end);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_LOOKUP) begin
						state_d = ST_LOOKUP;
					end else if (last) begin
						state_d = ST_FOLD;
					end
				end
			end
			ST_LOOKUP: begin
				if (stop) begin
					state_d = ST_IDLE;
				end
			end
			ST_FOLD: begin
				if (run_res.ready) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stop) begin
					if (ins_match) begin
						state_d = ST_WRITE;
					end else if (count_q >= DEPTH_C) begin
						state_d = ST_IDLE;
					end else if (pos == count_q) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				if (sh_done_q && !rd_vld_s1) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory and result control
	always_comb begin
		rd_en      = 1'b0;
		rd_addr    = idx_q[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = pos_q;
		wr_data    = {port_q, src_q, cookie_q, handle_q, run_res.length, run_res.checksum};
		res_en     = 1'b0;
		res_status = STATUS_NOT_FOUND;
		res_found  = 1'b0;
		case (state_q)
			ST_LOOKUP: begin
				rd_en = !stop && (idx_q < count_q);
				if (stop) begin
					res_en     = 1'b1;
					res_found  = lk_hit;
					res_status = lk_hit ? STATUS_FOUND : STATUS_NOT_FOUND;
				end
			end
			ST_SCAN: begin
				rd_en = !stop && (idx_q < count_q);
				if (stop && !ins_match && count_q >= DEPTH_C) begin
					res_en     = 1'b1;
					res_status = STATUS_FULL;
				end
			end
			ST_SHIFT: begin
				rd_en   = !sh_done_q;
				rd_addr = sh_q;
				// move the entry read last cycle up by one
				wr_en   = rd_vld_s1;
				wr_addr = AW'(rd_addr_s1 + 1'b1);
				wr_data = rdata_s1;
			end
			ST_WRITE: begin
				wr_en      = 1'b1;
				res_en     = 1'b1;
				res_status = ins_status_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			sh_done_q <= 1'b0;
			rd_vld_s1 <= 1'b0;
			done      <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			done      <= res_en;
			if (accept) begin
				idx_q <= '0;
			end else if (rd_en && (state_q == ST_LOOKUP || state_q == ST_SCAN)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (state_q == ST_SCAN) begin
				sh_done_q <= 1'b0;
			end else if (state_q == ST_SHIFT && rd_en) begin
				sh_done_q <= (sh_q == pos_q);
			end
			if (state_q == ST_WRITE && ins_status_q == STATUS_INSERTED) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= rd_addr;
		if (accept) begin
			port_q   <= port;
			src_q    <= src_port;
			cookie_q <= cookie_kind;
			handle_q <= payload_handle & hmask;
		end
		if (state_q == ST_SCAN && stop) begin
			pos_q        <= pos[AW-1:0];
			sh_q         <= AW'(count_q - 1'b1);
			ins_status_q <= ins_match ? STATUS_REPLACED : STATUS_INSERTED;
		end else if (state_q == ST_SHIFT && rd_en) begin
			sh_q <= sh_q - 1'b1;
		end
		if (res_en) begin
			status <= res_status;
			if (res_found) begin
				out_length      <= rdata_s1[LEN_LSB +: 16];
				out_src_port    <= rdata_s1[SRC_LSB +: 17];
				out_checksum    <= rdata_s1[SUM_LSB +: 16];
				out_cookie_kind <= rdata_s1[CK_LSB +: 3];
				out_handle      <= rdata_s1[HND_LSB +: HANDLE_BITS];
			end else begin
				out_length      <= '0;
				out_src_port    <= '0;
				out_checksum    <= '0;
				out_cookie_kind <= '0;
				out_handle      <= '0;
			end
		end
	end

endmodule

// ===== tb/tb_pkpt_check_pkg.sv =====
`timescale 1ns / 100ps
package tb_pkpt_check_pkg;
	import pkpt_pkg::*;

	typedef struct packed {
		logic                       cmd;
		logic [15:0]                port;
		logic [16:0]                src_port;
		logic [2:0]                 cookie_kind;
		logic [HANDLE_BITS_DEF-1:0] handle;
		logic [7:0]                 data_byte;
		logic                       data_valid;
		logic                       last;
	} table_cmd_t;

	typedef struct packed {
		logic [2:0]                 status;
		logic [15:0]                length;
		logic [16:0]                src_port;
		logic [15:0]                checksum;
		logic [2:0]                 cookie_kind;
		logic [HANDLE_BITS_DEF-1:0] handle;
	} table_reply_t;

	class payload_table_scoreboard;
		logic [15:0]                entry_port[TABLE_DEPTH_DEF];
		logic [16:0]                entry_src[TABLE_DEPTH_DEF];
		logic [2:0]                 entry_cookie[TABLE_DEPTH_DEF];
		logic [HANDLE_BITS_DEF-1:0] entry_handle[TABLE_DEPTH_DEF];
		logic [15:0]                entry_length[TABLE_DEPTH_DEF];
		logic [15:0]                entry_csum[TABLE_DEPTH_DEF];
		int                         entry_total;
		logic [31:0]                pair_sum;
		logic [15:0]                byte_count;
		logic [7:0]                 high_byte;
		bit                         high_waiting;
		table_reply_t               awaited_replies[$];
		int                         mismatches;

		function new();
			entry_total = 0;
			pair_sum = '0;
			byte_count = '0;
			high_byte = '0;
			high_waiting = 1'b0;
			mismatches = 0;
		endfunction

		function int table_size();
			return entry_total;
		endfunction

		function int pending_count();
			return awaited_replies.size();
		endfunction

		// advance the table model by one accepted transaction, queue its reply if any
		function void note_transaction(table_cmd_t c);
			table_reply_t r;
			logic [31:0]  total;
			logic [2:0]   st;
			int           j;
			int           k;
			bit           hit;
			r = '0;
			if (c.cmd == CMD_LOOKUP) begin
				r.status = STATUS_NOT_FOUND;
				hit = 1'b0;
				for (j = 0; j < entry_total; j++) begin
					if (!hit && entry_port[j] == c.port) begin
						hit = 1'b1;
						r.status = STATUS_FOUND;
						r.length = entry_length[j];
						r.src_port = entry_src[j];
						r.checksum = entry_csum[j];
						r.cookie_kind = entry_cookie[j];
						r.handle = entry_handle[j];
					end
				end
				awaited_replies.push_back(r);
				return;
			end
			if (c.data_valid) begin
				if (byte_count != 16'hFFFF)
					byte_count = byte_count + 16'd1;
				if (high_waiting) begin
					pair_sum = pair_sum + {16'h0, high_byte, c.data_byte};
					high_waiting = 1'b0;
					high_byte = '0;
				end else begin
					high_byte = c.data_byte;
					high_waiting = 1'b1;
				end
			end
			if (!c.last)
				return;
			// pad an odd trailing byte with a zero low byte, then fold three times
			total = pair_sum + (high_waiting ? {16'h0, high_byte, 8'h00} : 32'h0);
			repeat (3)
				total = {16'h0, total[15:0]} + {16'h0, total[31:16]};
			j = 0;
			while (j < entry_total && entry_port[j] < c.port)
				j++;
			if (j < entry_total && entry_port[j] == c.port) begin
				st = STATUS_REPLACED;
			end else if (entry_total >= TABLE_DEPTH_DEF) begin
				st = STATUS_FULL;
			end else begin
				for (k = entry_total; k > j; k--) begin
					entry_port[k] = entry_port[k-1];
					entry_src[k] = entry_src[k-1];
					entry_cookie[k] = entry_cookie[k-1];
					entry_handle[k] = entry_handle[k-1];
					entry_length[k] = entry_length[k-1];
					entry_csum[k] = entry_csum[k-1];
				end
				entry_total++;
				st = STATUS_INSERTED;
			end
			if (st != STATUS_FULL) begin
				entry_port[j] = c.port;
				entry_src[j] = c.src_port;
				entry_cookie[j] = c.cookie_kind;
				entry_handle[j] = c.handle;
				entry_length[j] = byte_count;
				entry_csum[j] = total[15:0];
			end
			pair_sum = '0;
			byte_count = '0;
			high_byte = '0;
			high_waiting = 1'b0;
			r.status = st;
			awaited_replies.push_back(r);
		endfunction

		task report_mismatch(string msg);
			if (mismatches < 200)
				$display("mismatch: %s", msg);
			mismatches++;
		endtask

		task check_result(table_reply_t got);
			table_reply_t want;
			if (awaited_replies.size() == 0) begin
				report_mismatch($sformatf("result with status %0d and nothing awaited",
					got.status));
				return;
			end
			want = awaited_replies.pop_front();
			if (got !== want)
				report_mismatch($sformatf({"got/exp status %0d/%0d len %h/%h src %h/%h ",
					"csum %h/%h cookie %0d/%0d handle %h/%h"},
					got.status, want.status, got.length, want.length,
					got.src_port, want.src_port, got.checksum, want.checksum,
					got.cookie_kind, want.cookie_kind, got.handle, want.handle));
		endtask
	endclass

endpackage

// ===== tb/tb_port_keyed_payload_table_unit.sv =====
`timescale 1ns / 100ps
module tb_port_keyed_payload_table_unit;
	import pkpt_pkg::*;
	import tb_pkpt_check_pkg::*;

	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int HB           = HANDLE_BITS_DEF;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int SETTLE       = 2 * DEPTH + 16;
	localparam int POOL_SIZE    = 72;
	localparam int RANDOM_ITEMS = 390;
	localparam int LONG_RUN     = 40;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	logic          cmd = CMD_LOOKUP;
	logic [15:0]   port = '0;
	logic [16:0]   src_port = '0;
	logic [2:0]    cookie_kind = '0;
	logic [HB-1:0] payload_handle = '0;
	logic [7:0]    data_byte = '0;
	logic          data_valid = 1'b0;
	logic          last = 1'b0;
	logic          done;
	logic [2:0]    status;
	logic [15:0]   out_length;
	logic [16:0]   out_src_port;
	logic [15:0]   out_checksum;
	logic [2:0]    out_cookie_kind;
	logic [HB-1:0] out_handle;

	payload_table_scoreboard sb;
	int unsigned cycle_count = 0;
	int          accepted = 0;
	bit          allow_gaps = 1'b1;
	logic [15:0] port_pool[POOL_SIZE];

	port_keyed_payload_table_unit #(
		.TABLE_DEPTH(DEPTH),
		.HANDLE_BITS(HB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.port(port),
		.src_port(src_port),
		.cookie_kind(cookie_kind),
		.payload_handle(payload_handle),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.last(last),
		.done(done),
		.status(status),
		.out_length(out_length),
		.out_src_port(out_src_port),
		.out_checksum(out_checksum),
		.out_cookie_kind(out_cookie_kind),
		.out_handle(out_handle)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_port_keyed_payload_table_unit NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin : result_monitor
		table_reply_t got;
		if (arst_n && done === 1'b1) begin
			got.status = status;
			got.length = out_length;
			got.src_port = out_src_port;
			got.checksum = out_checksum;
			got.cookie_kind = out_cookie_kind;
			got.handle = out_handle;
			sb.check_result(got);
		end
	end

	function automatic table_cmd_t make_cmd(logic c, logic [15:0] p, logic [16:0] s,
		logic [2:0] ck, logic [HB-1:0] h, logic [7:0] b, logic v, logic l);
		table_cmd_t t;
		t.cmd = c;
		t.port = p;
		t.src_port = s;
		t.cookie_kind = ck;
		t.handle = h;
		t.data_byte = b;
		t.data_valid = v;
		t.last = l;
		return t;
	endfunction

	function automatic table_cmd_t random_cmd();
		table_cmd_t t;
		t.cmd = CMD_BYTE;
		t.port = 16'($urandom_range(65535));
		t.src_port = ($urandom_range(9) == 0) ? 17'($urandom_range(131071, 65537))
			: 17'($urandom_range(65536));
		t.cookie_kind = 3'($urandom_range(7));
		t.handle = HB'($urandom);
		t.data_byte = 8'($urandom_range(255));
		t.data_valid = ($urandom_range(9) != 0);
		t.last = 1'b0;
		return t;
	endfunction

	function automatic table_cmd_t random_lookup();
		table_cmd_t t;
		t = random_cmd();
		t.cmd = CMD_LOOKUP;
		t.last = 1'($urandom_range(1));
		if ($urandom_range(4) != 0)
			t.port = port_pool[$urandom_range(POOL_SIZE - 1)];
		return t;
	endfunction

	// present one transaction and hold it until the block takes it
	task automatic send_cmd(input table_cmd_t c);
		if (allow_gaps && $urandom_range(99) < 19) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		cmd <= c.cmd;
		port <= c.port;
		src_port <= c.src_port;
		cookie_kind <= c.cookie_kind;
		payload_handle <= c.handle;
		data_byte <= c.data_byte;
		data_valid <= c.data_valid;
		last <= c.last;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_transaction(c);
		accepted++;
	endtask

	// insert run of n byte items; the last one carries the key and stored fields
	task automatic send_run(input logic [15:0] dest_port, input int n, input bit all_ones);
		table_cmd_t c;
		int         i;
		for (i = 0; i < n; i++) begin
			if (!all_ones && $urandom_range(9) == 0)
				send_cmd(random_lookup());
			c = random_cmd();
			c.last = (i == n - 1);
			if (all_ones) begin
				c.data_byte = 8'hFF;
				c.data_valid = 1'b1;
			end
			if (c.last)
				c.port = dest_port;
			send_cmd(c);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int          i;
		int          rand_begin;
		int          next_fresh;
		int          pick;
		int          n;
		logic [15:0] dest_port;
		sb = new();
		port_pool[0] = 16'h0000;
		port_pool[1] = 16'hFFFF;
		for (i = 2; i < POOL_SIZE; i++)
			port_pool[i] = 16'($urandom_range(65535));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, empty payload, odd single byte with top-range fields
		send_cmd(make_cmd(CMD_LOOKUP, 16'h0000, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_BYTE, 16'h0000, 17'h10000, 3'd0, '0, 8'h00, 1'b0, 1'b1));
		send_cmd(make_cmd(CMD_BYTE, 16'hFFFF, 17'h1FFFF, 3'd7, '1, 8'hFF, 1'b1, 1'b1));
		// three-byte run with a lookup and a no-byte item inside it
		send_cmd(make_cmd(CMD_BYTE, 16'h1111, 17'h0AAAA, 3'd5, '0, 8'h12, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_LOOKUP, 16'hFFFF, 17'h15555, 3'd2, '1, 8'hFF, 1'b1, 1'b1));
		send_cmd(make_cmd(CMD_BYTE, 16'h2222, 17'h0, 3'd1, '0, 8'h34, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_BYTE, 16'h3333, 17'h1, 3'd6, '1, 8'hA5, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_BYTE, 16'h8000, 17'h00001, 3'd3, 20'h5A5A5, 8'h56, 1'b1,
			1'b1));
		send_cmd(make_cmd(CMD_LOOKUP, 16'h8000, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_LOOKUP, 16'h0000, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_LOOKUP, 16'hFFFF, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_LOOKUP, 16'h1234, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		// replace 0x8000, closing with a last item that carries no byte
		send_cmd(make_cmd(CMD_BYTE, 16'h0F0F, 17'h0, 3'd0, '0, 8'hAB, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_BYTE, 16'hF0F0, 17'h0, 3'd0, '0, 8'hCD, 1'b1, 1'b0));
		send_cmd(make_cmd(CMD_BYTE, 16'h8000, 17'h0FFFF, 3'd4, 20'h0000F, 8'h00, 1'b0,
			1'b1));
		// middle insert shifts the upper entries
		send_cmd(make_cmd(CMD_BYTE, 16'h7FFF, 17'h12345, 3'd2, 20'hABCDE, 8'h00, 1'b1,
			1'b1));
		send_cmd(make_cmd(CMD_LOOKUP, 16'h8000, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));
		send_cmd(make_cmd(CMD_LOOKUP, 16'h7FFF, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));

		// hold off until the block has answered everything
		settle();

		// all-ones run checks the fold of a sum that runs over 16 bits
		send_run(16'h4000, LONG_RUN, 1'b1);
		send_cmd(make_cmd(CMD_LOOKUP, 16'h4000, 17'h0, 3'd0, '0, 8'h00, 1'b0, 1'b0));

		rand_begin = accepted;
		next_fresh = 0;
		while (accepted - rand_begin < RANDOM_ITEMS) begin
			// keep a long stretch free of gaps
			allow_gaps = !(accepted - rand_begin >= 150 && accepted - rand_begin < 280);
			pick = $urandom_range(99);
			if (pick < 25) begin
				send_cmd(random_lookup());
			end else begin
				if (next_fresh < POOL_SIZE && $urandom_range(4) != 0) begin
					dest_port = port_pool[next_fresh];
					next_fresh++;
				end else if ($urandom_range(4) == 0) begin
					dest_port = 16'($urandom_range(65535));
				end else begin
					dest_port = port_pool[$urandom_range(POOL_SIZE - 1)];
				end
				// short runs while filling so the table reaches full early
				if (sb.table_size() < DEPTH) begin
					n = $urandom_range(3, 1);
				end else begin
					pick = $urandom_range(99);
					if (pick < 15)
						n = 1;
					else if (pick < 70)
						n = $urandom_range(5, 2);
					else if (pick < 95)
						n = $urandom_range(16, 6);
					else
						n = $urandom_range(48, 17);
				end
				send_run(dest_port, n, 1'b0);
			end
		end
		allow_gaps = 1'b1;

		settle();
		if (sb.mismatches == 0)
			$display("tb_port_keyed_payload_table_unit OK");
		else
			$display("tb_port_keyed_payload_table_unit NOT OK");
		$finish;
	end

endmodule
